// ===== design/mow_pkg.sv =====
// Median-of-window package: cell control and state types, sample width.
// No dependencies; imported by mow_cell and median_of_window.
package mow_pkg;

  localparam int SampleW = 16;
  localparam int CountW  = 5;

  typedef logic signed [SampleW-1:0] sample_t;

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    sample_t  sample;
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IN,
    ST_SEEK,
    ST_CALC
  } mow_state_t;

endpackage

// ===== design/mow_cell.sv =====
// One cell of the sorted insertion chain: holds one sample.
// Depends on mow_pkg.
module mow_cell import mow_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_occupied,
  input  logic       left_gt,
  input  sample_t    left_value,
  input  sample_t    right_value,
  output sample_t    value,
  output logic       gt
);

  sample_t value_r;
  sample_t value_nxt;
  logic    take;

  assign value = value_r;
  assign gt    = occupied && (value_r > ctrl.sample);
  // Take a value when this entry moves up, or when it is the first free slot.
  assign take  = gt || (!occupied && left_occupied);

  always_comb begin
    value_nxt = value_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (take) begin
          value_nxt = left_gt ? left_value : ctrl.sample;
        end
      end
      OP_SHIFT: value_nxt = right_value;
      default:  value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== design/median_of_window.sv =====
// Median of a set of signed samples, kept sorted in a chain of MAX_SAMPLES cells.
// Throughput: one sample per cycle while a set fills; a sample marked last then goes
// through the steps insert, shift the chain to its middle, capture the middle pair,
// average. An output stall holds the average step. Reset (rst_n low, synchronous)
// clears count, drop flag, seek index, state and out_valid; the sample cells are
// not reset.
module median_of_window import mow_pkg::*; #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_sample,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_median,
  output logic [CountW-1:0]   out_sample_count,
  output logic                out_overflow
);

  // Count must be able to hold MAX_SAMPLES itself.
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  // The upper middle element sits next to the head once the chain is shifted.
  localparam int HI_IDX = (MAX_SAMPLES > 1) ? 1 : 0;

  mow_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] seek_r;
  logic          drop_r;
  sample_t       lo_r, hi_r;

  logic          out_valid_r;
  sample_t       median_r;
  logic [CountW-1:0] count_out_r;
  logic          overflow_r;

  cell_ctrl_t    ctrl;
  logic          in_xfer;
  logic          full;
  logic [CW-1:0] half;
  logic [CW-1:0] target;
  logic          at_target;
  logic          load_out;

  sample_t vals [MAX_SAMPLES];
  logic    gts  [MAX_SAMPLES];
  logic    occ  [MAX_SAMPLES];

  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;

  assign in_xfer   = in_valid && !in_stall;
  assign full      = (cnt_r == CW'(MAX_SAMPLES));
  assign half      = cnt_r >> 1;
  // Odd count: the middle element; even count: the lower of the middle pair.
  assign target    = cnt_r[0] ? half : half - CW'(1);
  assign at_target = (seek_r == target);
  assign load_out  = (state_r == ST_CALC) && (!out_valid_r || !out_stall);

  // Chain of cells; each entry below the count is occupied, so the occupied
  // cells form a prefix and the larger-than-sample cells a suffix of it.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    assign occ[i] = (CW'(i) < cnt_r);
    if (i == 0) begin : g_head
      mow_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .occupied     (occ[i]),
        .left_occupied(1'b1),
        .left_gt      (1'b0),
        .left_value   (ctrl.sample),
        .right_value  (vals[(MAX_SAMPLES > 1) ? 1 : 0]),
        .value        (vals[i]),
        .gt           (gts[i])
      );
    end else begin : g_body
      mow_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .occupied     (occ[i]),
        .left_occupied(occ[i-1]),
        .left_gt      (gts[i-1]),
        .left_value   (vals[i-1]),
        .right_value  (vals[(i < MAX_SAMPLES - 1) ? i + 1 : i]),
        .value        (vals[i]),
        .gt           (gts[i])
      );
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IN:   if (in_xfer && in_last) state_nxt = ST_SEEK;
      ST_SEEK: if (at_target) state_nxt = ST_CALC;
      ST_CALC: if (load_out) state_nxt = ST_IN;
      default: state_nxt = ST_IN;
    endcase
  end

  // Outputs of the controller: chain operation and input stall.
  always_comb begin
    in_stall    = (state_r != ST_IN);
    ctrl.sample = in_sample;
    ctrl.op     = OP_HOLD;
    unique case (state_r)
      ST_IN:   if (in_valid && !full) ctrl.op = OP_INSERT;
      ST_SEEK: if (!at_target) ctrl.op = OP_SHIFT;
      ST_CALC: ctrl.op = OP_HOLD;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  // Mean of the middle pair, truncated toward zero (an odd count pairs the
  // middle element with itself).
  assign sum     = {lo_r[15], lo_r} + {hi_r[15], hi_r};
  assign sum_adj = sum + {16'b0, sum[16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      seek_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        // Keep the sample if there is room, otherwise drop it and flag.
        if (!full) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          drop_r <= 1'b1;
        end
        seek_r <= '0;
      end
      if (state_r == ST_SEEK && !at_target) begin
        seek_r <= seek_r + CW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        drop_r      <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_SEEK && at_target) begin
      lo_r <= vals[0];
      hi_r <= cnt_r[0] ? vals[0] : vals[HI_IDX];
    end
    if (load_out) begin
      median_r    <= sum_adj[16:1];
      count_out_r <= CountW'(cnt_r);
      overflow_r  <= drop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median       = median_r;
  assign out_sample_count = count_out_r;
  assign out_overflow     = overflow_r;

endmodule
